[src/graph_partition_contraction_top_macros.svh]
// Assertion macros shared by the graph partition contraction RTL.
`ifndef GRAPH_PARTITION_CONTRACTION_TOP_MACROS_SVH
`define GRAPH_PARTITION_CONTRACTION_TOP_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is asserted.
`define GPC_ASSERT_IMP(name, rst_n, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on i_clk, off while reset is asserted.
`define GPC_ASSERT_NXT(name, rst_n, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[src/gpc_pkg.sv]
// Shared constants, types and helper functions for the partition contraction block.
package gpc_pkg;

    localparam int NODE_COUNT  = 1024;
    localparam int PART_COUNT  = 64;
    localparam int WEIGHT_BITS = 32;

    localparam int NODE_AW    = $clog2(NODE_COUNT);
    localparam int PART_AW    = $clog2(PART_COUNT);
    localparam int PAIR_COUNT = PART_COUNT * PART_COUNT;
    localparam int PAIR_AW    = $clog2(PAIR_COUNT);

    // Port field widths
    localparam int REQ_W       = 3;
    localparam int NODE_W      = 10;
    localparam int PFIELD_W    = 6;
    localparam int IN_WEIGHT_W = 31;
    localparam int OUT_VALUE_W = 32;
    localparam int PAIR_CNT_W  = 13;

    // Configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic REG_MERGE_MODE = 1'b0;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_LOAD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_NWEIGHT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_EDGE    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RD_PART = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RD_PAIR = 3'd4;

    typedef logic [2:0] t_op;
    localparam t_op OP_NOP     = 3'd0;
    localparam t_op OP_PWADD   = 3'd1;
    localparam t_op OP_SKIP    = 3'd2;
    localparam t_op OP_EDGE    = 3'd3;
    localparam t_op OP_RD_PART = 3'd4;
    localparam t_op OP_RD_PAIR = 3'd5;

    typedef logic [WEIGHT_BITS-1:0] t_weight;
    typedef logic [PART_AW-1:0]     t_part;

    // Classified command handed from front to back
    typedef struct packed {
        t_op     op;
        t_part   part_a;
        t_part   part_b;
        t_weight weight;
    } t_cmd;

    // One pair store word: valid flag plus weight
    typedef struct packed {
        logic    valid;
        t_weight weight;
    } t_pair_word;

    function automatic t_weight clamp_w(input logic [IN_WEIGHT_W-1:0] w);
        logic [63:0] w64;
        logic [63:0] wmax;
        w64  = 64'(w);
        wmax = (64'd1 << WEIGHT_BITS) - 64'd1;
        return (w64 > wmax) ? '1 : t_weight'(w64);
    endfunction

    function automatic t_weight sat_add(input t_weight a, input t_weight b);
        logic [WEIGHT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WEIGHT_BITS] ? '1 : s[WEIGHT_BITS-1:0];
    endfunction

    function automatic logic [OUT_VALUE_W-1:0] to_out(input t_weight v);
        logic [63:0] v64;
        v64 = 64'(v);
        return (v64 > 64'hFFFF_FFFF) ? '1 : OUT_VALUE_W'(v64);
    endfunction

endpackage

[src/gpc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/gpc_front.sv]
// Front end: accepts requests, looks up node partitions and classifies them into commands.
module gpc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [gpc_pkg::REQ_W-1:0]         i_req_type,
    input  logic [gpc_pkg::NODE_W-1:0]        i_node_a,
    input  logic [gpc_pkg::NODE_W-1:0]        i_node_b,
    input  logic [gpc_pkg::PFIELD_W-1:0]      i_part_a,
    input  logic [gpc_pkg::PFIELD_W-1:0]      i_part_b,
    input  logic [gpc_pkg::IN_WEIGHT_W-1:0]   i_weight,
    input  logic                              i_hold,
    input  logic                              i_q_full,
    output logic                              o_push,
    output gpc_pkg::t_cmd                     o_cmd
);

    localparam logic [1:0] F_IDLE   = 2'd0;
    localparam logic [1:0] F_NODE   = 2'd1;
    localparam logic [1:0] F_EDGE_A = 2'd2;
    localparam logic [1:0] F_EDGE_B = 2'd3;

    logic [1:0]                     r_state, n_state;
    logic [gpc_pkg::NODE_W-1:0]     r_node_b;
    gpc_pkg::t_weight               r_weight;
    gpc_pkg::t_part                 r_src, n_src;

    logic                           accept;
    logic                           map_we;
    logic [gpc_pkg::NODE_AW-1:0]    map_waddr;
    gpc_pkg::t_part                 map_wdata;
    logic [gpc_pkg::NODE_AW-1:0]    map_raddr;
    gpc_pkg::t_part                 map_rd;

    gpc_ram #(
        .WIDTH (gpc_pkg::PART_AW),
        .DEPTH (gpc_pkg::NODE_COUNT)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rd)
    );

    // queue space is checked at accept; only this module pushes, so it is still there later
    assign o_stall = (r_state != F_IDLE) || i_q_full || i_hold;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_state        = r_state;
        n_src          = r_src;
        map_we         = 1'b0;
        map_waddr      = i_node_a[gpc_pkg::NODE_AW-1:0];
        map_wdata      = i_part_a[gpc_pkg::PART_AW-1:0];
        map_raddr      = i_node_a[gpc_pkg::NODE_AW-1:0];
        o_push         = 1'b0;
        o_cmd.op       = gpc_pkg::OP_NOP;
        o_cmd.part_a   = i_part_a[gpc_pkg::PART_AW-1:0];
        o_cmd.part_b   = i_part_b[gpc_pkg::PART_AW-1:0];
        o_cmd.weight   = gpc_pkg::clamp_w(i_weight);
        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        gpc_pkg::REQ_LOAD: begin
                            map_we = 1'b1;
                            o_push = 1'b1;
                        end
                        gpc_pkg::REQ_NWEIGHT: begin
                            n_state = F_NODE;
                        end
                        gpc_pkg::REQ_EDGE: begin
                            n_state = F_EDGE_A;
                        end
                        gpc_pkg::REQ_RD_PART: begin
                            o_cmd.op = gpc_pkg::OP_RD_PART;
                            o_push   = 1'b1;
                        end
                        gpc_pkg::REQ_RD_PAIR: begin
                            o_cmd.op = gpc_pkg::OP_RD_PAIR;
                            o_push   = 1'b1;
                        end
                        default: begin
                            o_push = 1'b1;
                        end
                    endcase
                end
            end
            F_NODE: begin
                o_cmd.op     = gpc_pkg::OP_PWADD;
                o_cmd.part_a = map_rd;
                o_cmd.weight = r_weight;
                o_push       = 1'b1;
                n_state      = F_IDLE;
            end
            F_EDGE_A: begin
                n_src     = map_rd;
                map_raddr = r_node_b[gpc_pkg::NODE_AW-1:0];
                n_state   = F_EDGE_B;
            end
            F_EDGE_B: begin
                o_cmd.op     = (r_src == map_rd) ? gpc_pkg::OP_SKIP : gpc_pkg::OP_EDGE;
                o_cmd.part_a = r_src;
                o_cmd.part_b = map_rd;
                o_cmd.weight = r_weight;
                o_push       = 1'b1;
                n_state      = F_IDLE;
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_src <= n_src;
        if (accept) begin
            r_node_b <= i_node_b;
            r_weight <= gpc_pkg::clamp_w(i_weight);
        end
    end

endmodule

[src/gpc_queue.sv]
// Short command queue between the front end and the back end.
`include "graph_partition_contraction_top_macros.svh"

module gpc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gpc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output gpc_pkg::t_cmd o_cmd
);

    gpc_pkg::t_cmd                 r_mem [gpc_pkg::QUEUE_DEPTH];
    logic [gpc_pkg::QUEUE_AW-1:0]  r_wr, r_rd;
    logic [gpc_pkg::QUEUE_AW:0]    r_count;
    logic                          do_pop;

    assign o_full  = (r_count == (gpc_pkg::QUEUE_AW+1)'(gpc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // the front end only pushes into space it reserved at accept time
    `GPC_ASSERT_IMP(a_no_push_full, i_rst_n, i_push, !o_full || do_pop)

endmodule

[src/gpc_back.sv]
// Back end: read-modify-write of partition and pair stores, pair counter and result register.
`include "graph_partition_contraction_top_macros.svh"

module gpc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_merge_mode,
    input  logic                                i_q_valid,
    input  gpc_pkg::t_cmd                       i_cmd,
    output logic                                o_pop,
    output logic                                o_clearing,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [gpc_pkg::OUT_VALUE_W-1:0]     o_read_value,
    output logic                                o_read_present,
    output logic                                o_edge_skipped,
    output logic                                o_new_pair,
    output logic [gpc_pkg::PAIR_CNT_W-1:0]      o_pair_count
);

    localparam logic [1:0] B_CLEAR = 2'd0;
    localparam logic [1:0] B_IDLE  = 2'd1;
    localparam logic [1:0] B_EXEC  = 2'd2;

    localparam int PWORD_W = gpc_pkg::WEIGHT_BITS + 1;

    logic [1:0]                         r_state, n_state;
    logic [gpc_pkg::PAIR_AW-1:0]        r_clr, n_clr;
    gpc_pkg::t_cmd                      r_cmd, n_cmd;
    logic [gpc_pkg::PART_COUNT-1:0]     r_pvalid, n_pvalid;
    logic [gpc_pkg::PAIR_CNT_W-1:0]     r_pair_cnt, n_pair_cnt;

    logic                               r_out_valid, n_out_valid;
    logic [gpc_pkg::OUT_VALUE_W-1:0]    r_out_value, n_out_value;
    logic                               r_out_present, n_out_present;
    logic                               r_out_skip, n_out_skip;
    logic                               r_out_new, n_out_new;
    logic [gpc_pkg::PAIR_CNT_W-1:0]     r_out_pair_cnt;

    logic                               out_take;

    logic                               part_we;
    gpc_pkg::t_weight                   part_wdata;
    gpc_pkg::t_weight                   part_rd;

    logic                               pair_we;
    logic [gpc_pkg::PAIR_AW-1:0]        pair_waddr;
    gpc_pkg::t_pair_word                pair_wdata;
    logic [PWORD_W-1:0]                 pair_rd_raw;
    gpc_pkg::t_pair_word                pair_rd;

    gpc_ram #(
        .WIDTH (gpc_pkg::WEIGHT_BITS),
        .DEPTH (gpc_pkg::PART_COUNT)
    ) u_part_ram (
        .i_clk   (i_clk),
        .i_we    (part_we),
        .i_waddr (r_cmd.part_a),
        .i_wdata (part_wdata),
        .i_raddr (i_cmd.part_a),
        .o_rdata (part_rd)
    );

    gpc_ram #(
        .WIDTH (PWORD_W),
        .DEPTH (gpc_pkg::PAIR_COUNT)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (pair_waddr),
        .i_wdata (pair_wdata),
        .i_raddr ({i_cmd.part_a, i_cmd.part_b}),
        .o_rdata (pair_rd_raw)
    );

    assign pair_rd    = pair_rd_raw;
    assign out_take   = r_out_valid && !i_stall;
    assign o_clearing = (r_state == B_CLEAR);

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_cmd         = r_cmd;
        n_pvalid      = r_pvalid;
        n_pair_cnt    = r_pair_cnt;
        n_out_valid   = r_out_valid && !out_take;
        n_out_value   = r_out_value;
        n_out_present = r_out_present;
        n_out_skip    = r_out_skip;
        n_out_new     = r_out_new;
        o_pop         = 1'b0;
        part_we       = 1'b0;
        part_wdata    = r_cmd.weight;
        pair_we       = 1'b0;
        pair_waddr    = {r_cmd.part_a, r_cmd.part_b};
        pair_wdata    = '{valid: 1'b1, weight: r_cmd.weight};
        case (r_state)
            B_CLEAR: begin
                pair_we    = 1'b1;
                pair_waddr = r_clr;
                pair_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == gpc_pkg::PAIR_AW'(gpc_pkg::PAIR_COUNT - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                // read addresses come from the queue head, data is ready in B_EXEC
                if (i_q_valid && (!r_out_valid || out_take)) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_state = B_EXEC;
                end
            end
            B_EXEC: begin
                n_out_valid   = 1'b1;
                n_out_value   = '0;
                n_out_present = 1'b0;
                n_out_skip    = 1'b0;
                n_out_new     = 1'b0;
                n_state       = B_IDLE;
                case (r_cmd.op)
                    gpc_pkg::OP_PWADD: begin
                        part_we = 1'b1;
                        if (r_pvalid[r_cmd.part_a]) begin
                            part_wdata = gpc_pkg::sat_add(part_rd, r_cmd.weight);
                        end
                        n_pvalid[r_cmd.part_a] = 1'b1;
                    end
                    gpc_pkg::OP_SKIP: begin
                        n_out_skip = 1'b1;
                    end
                    gpc_pkg::OP_EDGE: begin
                        if (!pair_rd.valid) begin
                            pair_we   = 1'b1;
                            n_out_new = 1'b1;
                            if (r_pair_cnt != '1) begin
                                n_pair_cnt = r_pair_cnt + 1'b1;
                            end
                        end else if (!i_merge_mode) begin
                            pair_we           = 1'b1;
                            pair_wdata.weight = gpc_pkg::sat_add(pair_rd.weight,
                                                                 gpc_pkg::t_weight'(1));
                        end else if (pair_rd.weight < r_cmd.weight) begin
                            pair_we = 1'b1;
                        end
                    end
                    gpc_pkg::OP_RD_PART: begin
                        if (r_pvalid[r_cmd.part_a]) begin
                            n_out_present = 1'b1;
                            n_out_value   = gpc_pkg::to_out(part_rd);
                        end
                    end
                    gpc_pkg::OP_RD_PAIR: begin
                        if (pair_rd.valid) begin
                            n_out_present = 1'b1;
                            n_out_value   = gpc_pkg::to_out(pair_rd.weight);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_pvalid    <= '0;
            r_pair_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pvalid    <= n_pvalid;
            r_pair_cnt  <= n_pair_cnt;
            r_out_valid <= n_out_valid;
        end
        r_cmd         <= n_cmd;
        r_out_value   <= n_out_value;
        r_out_present <= n_out_present;
        r_out_skip    <= n_out_skip;
        r_out_new     <= n_out_new;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_EXEC) begin
            r_out_pair_cnt <= n_pair_cnt;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_value   = r_out_value;
    assign o_read_present = r_out_present;
    assign o_edge_skipped = r_out_skip;
    assign o_new_pair     = r_out_new;
    assign o_pair_count   = r_out_pair_cnt;

    `GPC_ASSERT_IMP(a_no_pop_clear, i_rst_n, r_state == B_CLEAR, !o_pop)
    `GPC_ASSERT_IMP(a_out_free_exec, i_rst_n, r_state == B_EXEC, !r_out_valid)
    `GPC_ASSERT_NXT(a_cnt_monotonic, i_rst_n, 1'b1, r_pair_cnt >= $past(r_pair_cnt))
    `GPC_ASSERT_NXT(a_new_pair_counts, i_rst_n,
        (r_state == B_EXEC) && n_out_new && (r_pair_cnt != '1),
        r_pair_cnt == $past(r_pair_cnt) + 1'b1)

endmodule

[src/graph_partition_contraction_top.sv]
// Top level of the graph partition contraction block: config register, front, queue and back.
//
// Contracts a partitioned graph into a partition graph, one request per item: load a node's
// partition, add a node weight to its partition, merge an edge into its partition pair, or
// read back a partition or pair weight. Every request gives exactly one result, in order.
// Front end: loads, reads and unused codes are pushed on accept; a node weight first looks
// up its node, and an edge looks up both nodes in turn, paced by the single read port of
// the node map (one lookup per cycle, registered). The back end reads the stores, then
// modifies and writes them before it takes the next command. A 4-entry command queue parts
// the two, and a result register parts the back end from the output, so new requests keep
// coming in, until the queue fills, while a result waits to be taken. After reset the pair
// store is swept clear, one of its 4096 entries a cycle; requests stall during the sweep,
// config writes are taken as usual. Config: merge_mode at APB byte address 0 (0: repeat edge
// adds one, 1: repeat edge keeps the larger weight); write it only while the block is idle.
module graph_partition_contraction_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [gpc_pkg::REQ_W-1:0]          i_req_type,
    input  logic [gpc_pkg::NODE_W-1:0]         i_node_a,
    input  logic [gpc_pkg::NODE_W-1:0]         i_node_b,
    input  logic [gpc_pkg::PFIELD_W-1:0]       i_part_a,
    input  logic [gpc_pkg::PFIELD_W-1:0]       i_part_b,
    input  logic [gpc_pkg::IN_WEIGHT_W-1:0]    i_weight,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [gpc_pkg::OUT_VALUE_W-1:0]    o_read_value,
    output logic                               o_read_present,
    output logic                               o_edge_skipped,
    output logic                               o_new_pair,
    output logic [gpc_pkg::PAIR_CNT_W-1:0]     o_pair_count,
    // APB config port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gpc_pkg::CFG_AW-1:0]         paddr,
    input  logic [gpc_pkg::CFG_DW-1:0]         pwdata,
    output logic [gpc_pkg::CFG_DW-1:0]         prdata,
    output logic                               pready
);

    logic          r_merge_mode;
    logic          cfg_wr;
    logic          clearing;
    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    gpc_pkg::t_cmd push_cmd;
    gpc_pkg::t_cmd head_cmd;

    // register index is paddr[2]; the low byte-offset bits are don't-care
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == gpc_pkg::REG_MERGE_MODE);
    assign prdata = (paddr[2] == gpc_pkg::REG_MERGE_MODE) ?
                    gpc_pkg::CFG_DW'(r_merge_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_merge_mode <= 1'b0;
        end else if (cfg_wr) begin
            r_merge_mode <= pwdata[0];
        end
    end

    // front: map lookups and request classification
    gpc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_req_type (i_req_type),
        .i_node_a   (i_node_a),
        .i_node_b   (i_node_b),
        .i_part_a   (i_part_a),
        .i_part_b   (i_part_b),
        .i_weight   (i_weight),
        .i_hold     (clearing),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    gpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // back: store updates, reads and the result register
    gpc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_merge_mode   (r_merge_mode),
        .i_q_valid      (q_valid),
        .i_cmd          (head_cmd),
        .o_pop          (q_pop),
        .o_clearing     (clearing),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_read_value   (o_read_value),
        .o_read_present (o_read_present),
        .o_edge_skipped (o_edge_skipped),
        .o_new_pair     (o_new_pair),
        .o_pair_count   (o_pair_count)
    );

endmodule

[tb/sv/graph_partition_contraction_top_test.sv]
// Self-checking testbench for the graph partition contraction top level.
`timescale 1ns / 1ps

module graph_partition_contraction_top_test;

    // Request codes that the block must ignore
    localparam logic [gpc_pkg::REQ_W-1:0] REQ_RSVD_LO = 3'd5;
    localparam logic [gpc_pkg::REQ_W-1:0] REQ_RSVD_HI = 3'd7;

    localparam logic [gpc_pkg::CFG_AW-1:0] MERGE_MODE_ADDR =
        gpc_pkg::CFG_AW'(4 * int'(gpc_pkg::REG_MERGE_MODE));

    localparam logic [gpc_pkg::IN_WEIGHT_W-1:0] W_IN_MAX = '1;
    localparam logic [gpc_pkg::OUT_VALUE_W-1:0] W_OUT_MAX = '1;
    localparam logic [63:0] W_CEIL = (64'd1 << gpc_pkg::WEIGHT_BITS) - 64'd1;
    localparam int unsigned PAIRS_CEIL = 8191;

    // Run shape. The limit covers the pair store sweep after reset plus
    // every request paying the slowest front end path, both idle bursts and the
    // long receiver hold, several times over.
    localparam int RAND_PER_PHASE = 500;
    localparam int PHASES = 4;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD = 300;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [gpc_pkg::REQ_W-1:0]       kind;
        logic [gpc_pkg::NODE_W-1:0]      node_a;
        logic [gpc_pkg::NODE_W-1:0]      node_b;
        logic [gpc_pkg::PFIELD_W-1:0]    part_a;
        logic [gpc_pkg::PFIELD_W-1:0]    part_b;
        logic [gpc_pkg::IN_WEIGHT_W-1:0] weight;
    } t_gpc_req;

    typedef struct packed {
        logic [gpc_pkg::OUT_VALUE_W-1:0] value;
        logic                            present;
        logic                            skipped;
        logic                            new_pair;
        logic [gpc_pkg::PAIR_CNT_W-1:0]  count;
    } t_gpc_res;

    // One row of the directed table: a request and, where it is obvious, the
    // result typed in by hand.
    typedef struct packed {
        t_gpc_req req;
        logic     typed;
        t_gpc_res want;
    } t_dir_row;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic [gpc_pkg::REQ_W-1:0]       i_req_type = '0;
    logic [gpc_pkg::NODE_W-1:0]      i_node_a = '0;
    logic [gpc_pkg::NODE_W-1:0]      i_node_b = '0;
    logic [gpc_pkg::PFIELD_W-1:0]    i_part_a = '0;
    logic [gpc_pkg::PFIELD_W-1:0]    i_part_b = '0;
    logic [gpc_pkg::IN_WEIGHT_W-1:0] i_weight = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [gpc_pkg::OUT_VALUE_W-1:0] o_read_value;
    logic                            o_read_present;
    logic                            o_edge_skipped;
    logic                            o_new_pair;
    logic [gpc_pkg::PAIR_CNT_W-1:0]  o_pair_count;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [gpc_pkg::CFG_AW-1:0]      paddr = '0;
    logic [gpc_pkg::CFG_DW-1:0]      pwdata = '0;
    logic [gpc_pkg::CFG_DW-1:0]      prdata;
    logic                            pready;

    graph_partition_contraction_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .i_part_a       (i_part_a),
        .i_part_b       (i_part_b),
        .i_weight       (i_weight),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_value   (o_read_value),
        .o_read_present (o_read_present),
        .o_edge_skipped (o_edge_skipped),
        .o_new_pair     (o_new_pair),
        .o_pair_count   (o_pair_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Contraction predictor state: our own copy of the node map, the
    // partition weights, the pair matrix and the merge rule. Weights are
    // held 64 bits wide so saturation at WEIGHT_BITS is explicit.
    // ------------------------------------------------------------------
    bit [gpc_pkg::PART_AW-1:0] map_part [gpc_pkg::NODE_COUNT];
    bit                        map_set  [gpc_pkg::NODE_COUNT];
    bit [63:0]                 part_wt  [gpc_pkg::PART_COUNT];
    bit                        part_seen[gpc_pkg::PART_COUNT];
    bit [63:0]                 pair_wt  [gpc_pkg::PAIR_COUNT];
    bit                        pair_seen[gpc_pkg::PAIR_COUNT];
    int unsigned               pair_total;
    bit                        merge_keep_max;

    // Nodes whose partition has been loaded; weight and edge requests only
    // ever name these, since a lookup of an unloaded node is undefined.
    int unsigned loaded_nodes[$];

    t_gpc_res  expected_results[$];
    t_dir_row  dir_rows[$];

    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned stall_left = 0;
    t_gpc_res    got_res;
    t_gpc_res    want_res;

    function automatic bit [63:0] sat_sum(input bit [63:0] a, input bit [63:0] b);
        bit [63:0] s;
        s = a + b;
        return (s > W_CEIL) ? W_CEIL : s;
    endfunction

    function automatic logic [gpc_pkg::OUT_VALUE_W-1:0] out_word(input bit [63:0] v);
        return (v > 64'(W_OUT_MAX)) ? W_OUT_MAX : gpc_pkg::OUT_VALUE_W'(v);
    endfunction

    // Applies one accepted request to the predictor and returns its result.
    function automatic t_gpc_res contract_step(input t_gpc_req r);
        t_gpc_res    res;
        bit [63:0]   w;
        int unsigned src;
        int unsigned dst;
        int unsigned idx;
        res = '0;
        w = 64'(r.weight);
        if (w > W_CEIL)
            w = W_CEIL;
        case (r.kind)
            gpc_pkg::REQ_LOAD: begin
                if (int'(r.node_a) < gpc_pkg::NODE_COUNT &&
                    int'(r.part_a) < gpc_pkg::PART_COUNT) begin
                    map_part[r.node_a] = gpc_pkg::PART_AW'(r.part_a);
                    if (!map_set[r.node_a]) begin
                        map_set[r.node_a] = 1'b1;
                        loaded_nodes.insert(loaded_nodes.size(), 32'(r.node_a));
                    end
                end
            end
            gpc_pkg::REQ_NWEIGHT: begin
                src = 32'(map_part[r.node_a]);
                if (part_seen[src]) begin
                    part_wt[src] = sat_sum(part_wt[src], w);
                end else begin
                    part_wt[src] = w;
                    part_seen[src] = 1'b1;
                end
            end
            gpc_pkg::REQ_EDGE: begin
                src = 32'(map_part[r.node_a]);
                dst = 32'(map_part[r.node_b]);
                if (src == dst) begin
                    res.skipped = 1'b1;
                end else begin
                    idx = src * gpc_pkg::PART_COUNT + dst;
                    if (!pair_seen[idx]) begin
                        pair_seen[idx] = 1'b1;
                        pair_wt[idx] = w;
                        res.new_pair = 1'b1;
                        if (pair_total < PAIRS_CEIL)
                            pair_total++;
                    end else if (!merge_keep_max) begin
                        pair_wt[idx] = sat_sum(pair_wt[idx], 64'd1);
                    end else if (pair_wt[idx] < w) begin
                        pair_wt[idx] = w;
                    end
                end
            end
            gpc_pkg::REQ_RD_PART: begin
                if (int'(r.part_a) < gpc_pkg::PART_COUNT && part_seen[r.part_a]) begin
                    res.value = out_word(part_wt[r.part_a]);
                    res.present = 1'b1;
                end
            end
            gpc_pkg::REQ_RD_PAIR: begin
                idx = int'(r.part_a) * gpc_pkg::PART_COUNT + int'(r.part_b);
                if (pair_seen[idx]) begin
                    res.value = out_word(pair_wt[idx]);
                    res.present = 1'b1;
                end
            end
            default: ;
        endcase
        res.count = gpc_pkg::PAIR_CNT_W'(pair_total);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random request generation
    // ------------------------------------------------------------------
    function automatic logic [gpc_pkg::NODE_W-1:0] pick_loaded();
        return gpc_pkg::NODE_W'(loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)]);
    endfunction

    // Mostly a few partitions so pairs repeat and edges fall inside one
    // partition now and then; sometimes the whole range.
    function automatic logic [gpc_pkg::PFIELD_W-1:0] pick_part();
        if ($urandom_range(0, 99) < 70)
            return gpc_pkg::PFIELD_W'($urandom_range(0, 7));
        return gpc_pkg::PFIELD_W'($urandom_range(0, gpc_pkg::PART_COUNT - 1));
    endfunction

    function automatic logic [gpc_pkg::REQ_W-1:0] REQ_LOG_RSVD(
        input logic [gpc_pkg::REQ_W-1:0] lo);
        return gpc_pkg::REQ_W'($urandom_range(int'(lo), int'(REQ_RSVD_HI)));
    endfunction

    function automatic t_gpc_req gen_req();
        t_gpc_req    r;
        int unsigned pick;
        // unused fields still get random content
        r.kind   = gpc_pkg::REQ_LOAD;
        r.node_a = gpc_pkg::NODE_W'($urandom);
        r.node_b = gpc_pkg::NODE_W'($urandom);
        r.part_a = gpc_pkg::PFIELD_W'($urandom);
        r.part_b = gpc_pkg::PFIELD_W'($urandom);
        case ($urandom_range(0, 3))
            0:       r.weight = W_IN_MAX;
            1:       r.weight = gpc_pkg::IN_WEIGHT_W'($urandom_range(0, 15));
            default: r.weight = gpc_pkg::IN_WEIGHT_W'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            r.kind = gpc_pkg::REQ_LOAD;
            if ($urandom_range(0, 99) < 70)
                r.node_a = gpc_pkg::NODE_W'($urandom_range(0, 31));
            r.part_a = pick_part();
        end else if (pick < 35) begin
            r.kind = gpc_pkg::REQ_NWEIGHT;
            r.node_a = pick_loaded();
        end else if (pick < 70) begin
            r.kind = gpc_pkg::REQ_EDGE;
            r.node_a = pick_loaded();
            r.node_b = pick_loaded();
        end else if (pick < 82) begin
            r.kind = gpc_pkg::REQ_RD_PART;
            if ($urandom_range(0, 99) < 60)
                r.part_a = gpc_pkg::PFIELD_W'(map_part[pick_loaded()]);
        end else if (pick < 95) begin
            r.kind = gpc_pkg::REQ_RD_PAIR;
            if ($urandom_range(0, 99) < 60) begin
                r.part_a = gpc_pkg::PFIELD_W'(map_part[pick_loaded()]);
                r.part_b = gpc_pkg::PFIELD_W'(map_part[pick_loaded()]);
            end
        end else begin
            r.kind = REQ_LOG_RSVD(REQ_RSVD_LO);
        end
        return r;
    endfunction

    function automatic void add_row(input logic [gpc_pkg::REQ_W-1:0] kind,
                                    input int unsigned na, input int unsigned nb,
                                    input int unsigned pa, input int unsigned pb,
                                    input logic [gpc_pkg::IN_WEIGHT_W-1:0] w,
                                    input bit typed,
                                    input logic [gpc_pkg::OUT_VALUE_W-1:0] value,
                                    input bit present, input bit skipped,
                                    input bit new_pair, input int unsigned count);
        t_dir_row row;
        row.req.kind     = kind;
        row.req.node_a   = gpc_pkg::NODE_W'(na);
        row.req.node_b   = gpc_pkg::NODE_W'(nb);
        row.req.part_a   = gpc_pkg::PFIELD_W'(pa);
        row.req.part_b   = gpc_pkg::PFIELD_W'(pb);
        row.req.weight   = w;
        row.typed        = typed;
        row.want.value   = value;
        row.want.present = present;
        row.want.skipped = skipped;
        row.want.new_pair = new_pair;
        row.want.count   = gpc_pkg::PAIR_CNT_W'(count);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // ------------------------------------------------------------------
    // Request side. Valid goes high with the payload and stays put until an
    // edge sees valid with no stall; the result is predicted at that edge.
    // Valid is only lowered by an idle burst or a drain, never here, so a
    // back-to-back request never sees valid assigned twice in one step.
    // ------------------------------------------------------------------
    task automatic send_req(input t_gpc_req r, input bit typed, input t_gpc_res want);
        t_gpc_res predicted;
        i_in_valid <= 1'b1;
        i_req_type <= r.kind;
        i_node_a   <= r.node_a;
        i_node_b   <= r.node_b;
        i_part_a   <= r.part_a;
        i_part_b   <= r.part_b;
        i_weight   <= r.weight;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = contract_step(r);
        expected_results.insert(expected_results.size(), typed ? want : predicted);
    endtask

    task automatic idle_gap();
        int unsigned n;
        if (idle_on && $urandom_range(0, 99) < 20) begin
            n = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every outstanding request has its result.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of merge_mode, then a read back. Only called while idle.
    task automatic write_merge_mode(input bit keep_max);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MERGE_MODE_ADDR;
        pwdata  <= gpc_pkg::CFG_DW'(keep_max);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        merge_keep_max = keep_max;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[0] !== keep_max) begin
            if (mismatches < 10)
                $display("merge_mode read back: expected %0d, got %0d", keep_max, prdata[0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: checks each taken result against the oldest expectation
    // and drives stall in random bursts, plus one long hold on request.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got_res = {o_read_value, o_read_present, o_edge_skipped, o_new_pair,
                           o_pair_count};
                if (expected_results.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result: value %h present %b skip %b new %b count %0d",
                                 o_read_value, o_read_present, o_edge_skipped, o_new_pair,
                                 o_pair_count);
                    mismatches++;
                end else begin
                    want_res = expected_results.pop_front();
                    if (got_res.value !== want_res.value ||
                        got_res.present !== want_res.present ||
                        got_res.skipped !== want_res.skipped ||
                        got_res.new_pair !== want_res.new_pair ||
                        got_res.count !== want_res.count) begin
                        if (mismatches < 10) begin
                            $display("mismatch exp: value %h pres %b skip %b new %b count %0d",
                                     want_res.value, want_res.present, want_res.skipped,
                                     want_res.new_pair, want_res.count);
                            $display("mismatch got: value %h pres %b skip %b new %b count %0d",
                                     got_res.value, got_res.present, got_res.skipped,
                                     got_res.new_pair, got_res.count);
                        end
                        mismatches++;
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (hold_request) begin
                // long hold: the block backs up and stalls its input
                hold_request = 1'b0;
                stall_left = LONG_HOLD - 1;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 99) < 15) begin
                stall_left = $urandom_range(0, 7);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("graph_partition_contraction_top_test: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Config is taken during the post-reset sweep; requests wait it out.
        write_merge_mode(1'b0);

        // Directed table. Nodes 0 and 5 go to partition 0, nodes 6 and 1023
        // to partition 63. Reads before any write come back absent, the
        // reserved codes do nothing, and partition 0 saturates.
        add_row(gpc_pkg::REQ_RD_PART, 0, 0, 0, 0, '0, 1, '0, 0, 0, 0, 0);
        add_row(gpc_pkg::REQ_RD_PAIR, 0, 0, 63, 63, '0, 1, '0, 0, 0, 0, 0);
        add_row(REQ_RSVD_LO, 1023, 1023, 63, 63, W_IN_MAX, 1, '0, 0, 0, 0, 0);
        add_row(REQ_RSVD_HI, 1023, 1023, 63, 63, W_IN_MAX, 1, '0, 0, 0, 0, 0);
        add_row(gpc_pkg::REQ_LOAD, 0, 0, 0, 0, '0, 1, '0, 0, 0, 0, 0);
        add_row(gpc_pkg::REQ_LOAD, 1023, 0, 63, 0, '0, 1, '0, 0, 0, 0, 0);
        add_row(gpc_pkg::REQ_LOAD, 5, 0, 0, 0, '0, 1, '0, 0, 0, 0, 0);
        add_row(gpc_pkg::REQ_LOAD, 6, 0, 63, 0, '0, 1, '0, 0, 0, 0, 0);
        add_row(gpc_pkg::REQ_NWEIGHT, 0, 0, 0, 0, W_IN_MAX, 1, '0, 0, 0, 0, 0);
        add_row(gpc_pkg::REQ_NWEIGHT, 5, 0, 0, 0, W_IN_MAX, 1, '0, 0, 0, 0, 0);
        add_row(gpc_pkg::REQ_NWEIGHT, 5, 0, 0, 0, W_IN_MAX, 1, '0, 0, 0, 0, 0);
        add_row(gpc_pkg::REQ_RD_PART, 0, 0, 0, 0, '0, 1, W_OUT_MAX, 1, 0, 0, 0);
        // edge inside partition 0
        add_row(gpc_pkg::REQ_EDGE, 0, 5, 0, 0, W_IN_MAX, 1, '0, 0, 1, 0, 0);
        // first edge of pair (0,63), then a repeat that adds one
        add_row(gpc_pkg::REQ_EDGE, 0, 1023, 0, 0, '0, 1, '0, 0, 0, 1, 1);
        add_row(gpc_pkg::REQ_EDGE, 5, 6, 0, 0, W_IN_MAX, 1, '0, 0, 0, 0, 1);
        add_row(gpc_pkg::REQ_RD_PAIR, 0, 0, 0, 63, '0, 1, 32'd1, 1, 0, 0, 1);
        add_row(gpc_pkg::REQ_EDGE, 1023, 0, 0, 0, W_IN_MAX, 1, '0, 0, 0, 1, 2);
        add_row(gpc_pkg::REQ_RD_PAIR, 0, 0, 63, 0, '0, 1, 32'h7FFF_FFFF, 1, 0, 0, 2);
        add_row(gpc_pkg::REQ_RD_PART, 0, 0, 63, 0, '0, 1, '0, 0, 0, 0, 2);
        add_row(gpc_pkg::REQ_NWEIGHT, 1023, 0, 0, 0, '0, 1, '0, 0, 0, 0, 2);
        add_row(gpc_pkg::REQ_RD_PART, 0, 0, 63, 0, '0, 1, '0, 1, 0, 0, 2);
        // self pair is never written
        add_row(gpc_pkg::REQ_RD_PAIR, 0, 0, 0, 0, '0, 1, '0, 0, 0, 0, 2);
        add_row(gpc_pkg::REQ_EDGE, 6, 5, 0, 0, gpc_pkg::IN_WEIGHT_W'($urandom), 0,
                '0, 0, 0, 0, 0);
        add_row(gpc_pkg::REQ_NWEIGHT, 6, 0, 0, 0, gpc_pkg::IN_WEIGHT_W'($urandom), 0,
                '0, 0, 0, 0, 0);
        add_row(gpc_pkg::REQ_RD_PART, 0, 0, 63, 0, '0, 0, '0, 0, 0, 0, 0);

        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
            idle_gap();
        end

        // Random phases alternate the merge rule; the last one runs flat out.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            write_merge_mode(phase % 2 == 0);
            idle_on = (phase != PHASES - 1);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (phase == 1 && n == RAND_PER_PHASE / 2)
                    drain();
                if (phase == 2 && n == 100)
                    hold_request = 1'b1;
                send_req(gen_req(), 1'b0, '0);
                idle_gap();
            end
        end

        drain();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("graph_partition_contraction_top_test: PASS");
        end else begin
            $display("graph_partition_contraction_top_test: FAIL");
        end
        $finish;
    end

endmodule
